FILE: rtl/scbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_pkg
// shared types and constants of the saturating counter branch predictor
// ----------------------------------------------------------------------------
package scbp_pkg;

    localparam int ADDR_W = 32;
    localparam int CTR_W  = 4;

    localparam logic [CTR_W-1:0] CTR_MAX          = 4'd15;
    localparam logic [CTR_W-1:0] CTR_MIN          = 4'd0;
    localparam logic [CTR_W-1:0] CTR_ALLOC_TAKEN  = 4'd8;
    localparam logic [CTR_W-1:0] CTR_ALLOC_NTAKEN = 4'd7;
    localparam logic [CTR_W-1:0] THRESH_RESET     = 4'd8;

    typedef enum logic [1:0] {
        MODE_PREDICT      = 2'd0,
        MODE_LEARN_TAKEN  = 2'd1,
        MODE_LEARN_NTAKEN = 2'd2,
        MODE_RESERVED     = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [ADDR_W-1:0] branch_address;
    } in_item_t;

    typedef struct packed {
        logic predict_taken;
        logic entry_hit;
    } out_item_t;

endpackage

FILE: rtl/scbp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_table
// predictor entry memory: one write port, one registered read port, and a
// clearing sweep after reset that zeroes every entry
// ----------------------------------------------------------------------------
module scbp_table #(
    parameter int DEPTH      = 1024,
    parameter int IDX_BITS   = 10,
    parameter int ENTRY_BITS = 27
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [IDX_BITS-1:0]   rd_addr,
    output logic [ENTRY_BITS-1:0] rd_data,
    input  logic                  wr_en,
    input  logic [IDX_BITS-1:0]   wr_addr,
    input  logic [ENTRY_BITS-1:0] wr_data,
    output logic                  clear_busy
);

    typedef enum logic [1:0] {
        CLR_SWEEP = 2'b01,
        CLR_DONE  = 2'b10
    } clr_state_t;

    localparam logic [IDX_BITS-1:0] LAST_ADDR = IDX_BITS'(DEPTH - 1);

    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rd_data_reg;

    clr_state_t            state_reg, state_next;
    logic [IDX_BITS-1:0]   clear_addr_reg, clear_addr_next;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [ENTRY_BITS-1:0] mem_wdata;

    // sweep one entry per cycle until the last address
    always_comb begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        case (state_reg)
            CLR_SWEEP: begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == LAST_ADDR) begin
                    state_next = CLR_DONE;
                end
            end
            CLR_DONE: begin
                clear_addr_next = clear_addr_reg;
            end
            default: begin
                state_next = CLR_SWEEP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= CLR_SWEEP;
            clear_addr_reg <= '0;
        end else begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    assign clear_busy = (state_reg != CLR_DONE);

    assign mem_we    = clear_busy || wr_en;
    assign mem_waddr = clear_busy ? clear_addr_reg : wr_addr;
    assign mem_wdata = clear_busy ? '0 : wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/scbp_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_update
// tag compare, prediction and saturating counter update for one entry
// ----------------------------------------------------------------------------
module scbp_update #(
    parameter int TAG_BITS = 22
) (
    input  scbp_pkg::mode_t                      mode,
    input  logic [TAG_BITS-1:0]                  tag,
    input  logic [scbp_pkg::CTR_W-1:0]           threshold,
    input  logic [TAG_BITS+scbp_pkg::CTR_W:0]    entry,
    output scbp_pkg::out_item_t                  result,
    output logic                                 learn,
    output logic [TAG_BITS+scbp_pkg::CTR_W:0]    entry_new
);
    import scbp_pkg::*;

    logic                entry_valid;
    logic [TAG_BITS-1:0] entry_tag;
    logic [CTR_W-1:0]    entry_ctr;
    logic                hit;
    logic [CTR_W-1:0]    ctr_new;

    assign {entry_valid, entry_tag, entry_ctr} = entry;

    assign hit = entry_valid && (entry_tag == tag);

    assign result.entry_hit     = hit;
    assign result.predict_taken = hit && (entry_ctr >= threshold);

    always_comb begin
        learn   = 1'b0;
        ctr_new = entry_ctr;
        case (mode)
            MODE_LEARN_TAKEN: begin
                learn = 1'b1;
                if (!hit) begin
                    ctr_new = CTR_ALLOC_TAKEN;
                end else if (entry_ctr != CTR_MAX) begin
                    ctr_new = entry_ctr + 1'b1;
                end
            end
            MODE_LEARN_NTAKEN: begin
                learn = 1'b1;
                if (!hit) begin
                    ctr_new = CTR_ALLOC_NTAKEN;
                end else if (entry_ctr != CTR_MIN) begin
                    ctr_new = entry_ctr - 1'b1;
                end
            end
            MODE_PREDICT, MODE_RESERVED: begin
                learn = 1'b0;
            end
            default: begin
                learn = 1'b0;
            end
        endcase
    end

    // a learning miss replaces the slot with the new tag
    assign entry_new = {1'b1, tag, ctr_new};

endmodule

FILE: rtl/saturating_counter_branch_predictor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_counter_branch_predictor_top
// direct-mapped tagged table of 4-bit saturating counters, consulted and
// trained per branch address
// ----------------------------------------------------------------------------
//  channel   direction   ports                       carries
//  s_        in          s_valid s_ready s_data      mode, branch_address
//  m_        out         m_valid m_ready m_data      predict_taken, entry_hit
//  cfg_      in          cfg_valid cfg_ready cfg_data taken_threshold
//
//  one item per cycle sustained while m_ready keeps up; a result reaches m_data
//  after its input transfer via the table read register, loaded at the transfer
//  edge with the update stage, which then loads m_data when the output allows
//  the rate is set by the single table read/write port pair; a write to the
//  slot read by the next item is forwarded from the write-back register
//  after reset a clearing sweep over all TABLE_ENTRIES entries zeroes the table;
//  s_ready stays low until it is done, cfg writes are taken throughout
//  a stalled result holds the update stage, which then holds s_ready low
//  TABLE_ENTRIES must be a power of two
// ----------------------------------------------------------------------------
module saturating_counter_branch_predictor_top #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int ADDRESS_BITS  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  scbp_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output scbp_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scbp_pkg::CTR_W-1:0]     cfg_data
);
    import scbp_pkg::*;

    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    // only the low ADDRESS_BITS of the address take part
    localparam int EFF_ADDR_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int TAG_BITS      = (EFF_ADDR_BITS > IDX_BITS) ?
                                   (EFF_ADDR_BITS - IDX_BITS) : 1;
    localparam int ENTRY_BITS    = 1 + TAG_BITS + CTR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((64'(1) << EFF_ADDR_BITS) - 64'(1));

    // config register
    logic [CTR_W-1:0]      thresh_reg, thresh_next;

    // update stage
    logic                  p_valid_reg, p_valid_next;
    mode_t                 p_mode_reg;
    logic [IDX_BITS-1:0]   p_slot_reg;
    logic [TAG_BITS-1:0]   p_tag_reg;

    // last table write, for forwarding
    logic                  wb_valid_reg, wb_valid_next;
    logic [IDX_BITS-1:0]   wb_slot_reg;
    logic [ENTRY_BITS-1:0] wb_entry_reg;

    // output register
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg;

    logic [ADDR_W-1:0]     addr_masked;
    logic [ADDR_W-1:0]     addr_shifted;
    logic [IDX_BITS-1:0]   s_slot;
    logic [TAG_BITS-1:0]   s_tag;
    logic                  s_xfer;
    logic                  p_done;
    logic                  clear_busy;
    logic [ENTRY_BITS-1:0] rd_entry;
    logic [ENTRY_BITS-1:0] cur_entry;
    logic                  fwd_hit;
    out_item_t             upd_result;
    logic                  upd_learn;
    logic [ENTRY_BITS-1:0] upd_entry;
    logic                  wr_en;

    // slot and tag split
    assign addr_masked  = s_data.branch_address & ADDR_MASK;
    assign addr_shifted = addr_masked >> IDX_BITS;
    assign s_slot       = addr_masked[IDX_BITS-1:0];
    assign s_tag        = addr_shifted[TAG_BITS-1:0];

    // handshakes
    assign p_done    = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clear_busy && (!p_valid_reg || p_done);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    scbp_table #(
        .DEPTH      (TABLE_ENTRIES),
        .IDX_BITS   (IDX_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (s_xfer),
        .rd_addr    (s_slot),
        .rd_data    (rd_entry),
        .wr_en      (wr_en),
        .wr_addr    (p_slot_reg),
        .wr_data    (upd_entry),
        .clear_busy (clear_busy)
    );

    // the read that went with this item may have missed the write made
    // at the same edge by the item ahead
    assign fwd_hit   = wb_valid_reg && (wb_slot_reg == p_slot_reg);
    assign cur_entry = fwd_hit ? wb_entry_reg : rd_entry;

    scbp_update #(
        .TAG_BITS (TAG_BITS)
    ) u_update (
        .mode      (p_mode_reg),
        .tag       (p_tag_reg),
        .threshold (thresh_reg),
        .entry     (cur_entry),
        .result    (upd_result),
        .learn     (upd_learn),
        .entry_new (upd_entry)
    );

    assign wr_en = p_done && upd_learn;

    always_comb begin
        thresh_next   = cfg_valid ? cfg_data : thresh_reg;
        p_valid_next  = s_xfer ? 1'b1 : (p_done ? 1'b0 : p_valid_reg);
        wb_valid_next = wr_en ? 1'b1 : wb_valid_reg;
        if (p_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= THRESH_RESET;
            p_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            thresh_reg   <= thresh_next;
            p_valid_reg  <= p_valid_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            p_mode_reg <= s_data.mode;
            p_slot_reg <= s_slot;
            p_tag_reg  <= s_tag;
        end
        if (wr_en) begin
            wb_slot_reg  <= p_slot_reg;
            wb_entry_reg <= upd_entry;
        end
        if (p_done) begin
            m_data_reg <= upd_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // no item enters while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_ready)
        else $error("input transfer possible during clearing sweep");

    // apart from the clearing sweep, the table is written only by a learning item leaving the update stage
    a_write_from_learn: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (p_valid_reg &&
                   (p_mode_reg == MODE_LEARN_TAKEN || p_mode_reg == MODE_LEARN_NTAKEN)))
        else $error("table write without a learning item");

    // an accepted item occupies the update stage on the next cycle
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> p_valid_reg)
        else $error("accepted item lost before update stage");

    // a finished update always lands in the output register
    a_done_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        p_done |=> m_valid_reg)
        else $error("update finished without a result");
`endif

endmodule

FILE: bench/scbp_branch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_branch_checker
// watches the branch, result and threshold channels of the predictor, keeps
// its own tagged counter table and compares each result transfer in order
// ----------------------------------------------------------------------------
module scbp_branch_checker #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  scbp_pkg::in_item_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  scbp_pkg::out_item_t        m_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [scbp_pkg::CTR_W-1:0] cfg_data,
    output int                         errors,
    output int                         results,
    output int                         hits,
    output int                         pending
);
    import scbp_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int TAG_W  = ADDR_W - SLOT_W;

    logic             slot_valid [TABLE_ENTRIES];
    logic [TAG_W-1:0] slot_tag [TABLE_ENTRIES];
    logic [CTR_W-1:0] slot_ctr [TABLE_ENTRIES];
    logic [CTR_W-1:0] threshold;

    out_item_t pending_predictions [$];
    out_item_t want;
    int        n_err  = 0;
    int        n_res  = 0;
    int        n_hits = 0;

    // prediction from the counter before the update, then training
    function automatic out_item_t lookup_and_train(input in_item_t item);
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic              hit;
        logic [CTR_W-1:0]  ctr;
        out_item_t         res;
        slot = item.branch_address[SLOT_W-1:0];
        tag  = item.branch_address[ADDR_W-1:SLOT_W];
        hit  = slot_valid[slot] && (slot_tag[slot] == tag);
        ctr  = slot_ctr[slot];
        res.entry_hit     = hit;
        res.predict_taken = hit && (ctr >= threshold);
        case (item.mode)
            MODE_LEARN_TAKEN: begin
                if (!hit) begin
                    slot_valid[slot] = 1'b1;
                    slot_tag[slot]   = tag;
                    slot_ctr[slot]   = CTR_ALLOC_TAKEN;
                end else if (ctr != CTR_MAX) begin
                    slot_ctr[slot] = ctr + 1'b1;
                end
            end
            MODE_LEARN_NTAKEN: begin
                if (!hit) begin
                    slot_valid[slot] = 1'b1;
                    slot_tag[slot]   = tag;
                    slot_ctr[slot]   = CTR_ALLOC_NTAKEN;
                end else if (ctr != CTR_MIN) begin
                    slot_ctr[slot] = ctr - 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
            threshold = THRESH_RESET;
            pending_predictions.delete();
        end else begin
            if (cfg_valid && cfg_ready) threshold = cfg_data;
            if (m_valid && m_ready) begin
                n_res++;
                if (pending_predictions.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected result, expected none, got taken=%0b hit=%0b",
                             $time, m_data.predict_taken, m_data.entry_hit);
                end else begin
                    want = pending_predictions.pop_front();
                    if (m_data !== want) begin
                        n_err++;
                        $display("%0t: mismatch, expected taken=%0b hit=%0b,",
                                 $time, want.predict_taken, want.entry_hit,
                                 " got taken=%0b hit=%0b",
                                 m_data.predict_taken, m_data.entry_hit);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = lookup_and_train(s_data);
                if (want.entry_hit) n_hits++;
                pending_predictions.push_back(want);
            end
        end
        errors  <= n_err;
        results <= n_res;
        hits    <= n_hits;
        pending <= pending_predictions.size();
    end

endmodule

FILE: bench/tb_saturating_counter_branch_predictor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_saturating_counter_branch_predictor_top
// stimulus and verdict for the branch predictor: directed corner cases of
// allocation, saturation, eviction and the unused mode, then random training
// runs over a small set of hot addresses under several thresholds, with
// bursty branch traffic, a stalling result side and one long result hold-off
// ----------------------------------------------------------------------------
module tb_saturating_counter_branch_predictor_top;
    import scbp_pkg::*;

    localparam int TABLE_ENTRIES   = 1024;
    localparam int ADDRESS_BITS    = 32;
    localparam int SLOT_W          = $clog2(TABLE_ENTRIES);
    localparam int N_HOT           = 24;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;

    // threshold per random phase; the fifth one is drawn at random
    localparam logic [CTR_W-1:0] PHASE_THRESHOLDS [N_PHASES] = '{
        4'd1, 4'd14, 4'd0, 4'd15, 4'd8, 4'd8
    };

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CTR_W-1:0] cfg_data  = '0;

    int chk_errors;
    int chk_results;
    int chk_hits;
    int chk_pending;

    int   branches_sent = 0;
    int   burst_left    = 0;
    logic hold_off_req  = 1'b0;

    logic [ADDR_W-1:0] hot_addresses [N_HOT];

    saturating_counter_branch_predictor_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    scbp_branch_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (chk_errors),
        .results   (chk_results),
        .hits      (chk_hits),
        .pending   (chk_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case a transfer never completes
    initial begin
        #3_000_000;
        $display("timeout: %0d branches sent, %0d results seen", branches_sent, chk_results);
        $display("RESULT: ERROR");
        $finish;
    end

    // one branch transfer; valid stays up while the burst lasts, otherwise
    // drops for a random gap
    task automatic push_branch(input mode_t mode, input logic [ADDR_W-1:0] addr);
        s_data  <= '{mode: mode, branch_address: addr};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        branches_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // drain all outstanding results before touching the threshold
    task automatic wait_idle();
        s_valid <= 1'b0;
        wait (chk_results == branches_sent);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [CTR_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic mode_t pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return MODE_PREDICT;
        if (r < 68) return MODE_LEARN_TAKEN;
        if (r < 95) return MODE_LEARN_NTAKEN;
        return MODE_RESERVED;
    endfunction

    // mostly hot addresses so entries get hit and trained, some cold noise
    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 99) < 80) return hot_addresses[$urandom_range(0, N_HOT - 1)];
        return $urandom();
    endfunction

    // training runs on one branch followed by a lookup, mixed with loose items
    task automatic run_phase(input int n_items);
        int                done_items;
        int                run_len;
        int                bias;
        logic [ADDR_W-1:0] addr;
        done_items = 0;
        while (done_items < n_items) begin
            if ($urandom_range(0, 9) < 4) begin
                addr    = pick_address();
                run_len = $urandom_range(3, 12);
                // bias 0 trains always taken, 4 always not taken
                bias    = $urandom_range(0, 4);
                repeat (run_len) begin
                    push_branch(($urandom_range(0, 3) < bias) ? MODE_LEARN_NTAKEN
                                                              : MODE_LEARN_TAKEN, addr);
                end
                push_branch(MODE_PREDICT, addr);
                done_items += run_len + 1;
            end else begin
                push_branch(pick_mode(), pick_address());
                done_items++;
            end
        end
    endtask

    // result side: stretches of different stall styles, plus one long
    // hold-off on request while branches keep coming
    initial begin
        int   style;
        int   stretch;
        int   tick;
        logic held_off;
        tick     = 0;
        held_off = 1'b0;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(10, 80);
            repeat (stretch) begin
                @(posedge aclk);
                tick++;
                if (hold_off_req && !held_off) begin
                    held_off = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                end
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    2:       m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        logic [CTR_W-1:0] thr;
        int               thr_pick;

        // hot set: every fourth address aliases the slot of its predecessor
        for (int i = 0; i < N_HOT; i++) begin
            hot_addresses[i] = $urandom();
            if (i % 4 == 3)
                hot_addresses[i][SLOT_W-1:0] = hot_addresses[i-1][SLOT_W-1:0];
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // threshold write lands during the clearing sweep after reset
        write_threshold(THRESH_RESET);

        // directed: misses at both address extremes
        push_branch(MODE_PREDICT, 32'h0000_0000);
        push_branch(MODE_PREDICT, 32'hFFFF_FFFF);
        // allocate taken, hit at the threshold
        push_branch(MODE_LEARN_TAKEN, 32'h0000_0000);
        push_branch(MODE_PREDICT, 32'h0000_0000);
        // one step down, below the threshold; unused mode leaves it alone
        push_branch(MODE_LEARN_NTAKEN, 32'h0000_0000);
        push_branch(MODE_RESERVED, 32'h0000_0000);
        push_branch(MODE_PREDICT, 32'h0000_0000);
        // same slot, other tag evicts the entry
        push_branch(MODE_LEARN_TAKEN, 32'h0000_0400);
        push_branch(MODE_PREDICT, 32'h0000_0000);
        // allocate not taken, walk down into saturation at zero
        repeat (9) push_branch(MODE_LEARN_NTAKEN, 32'hFFFF_FFFF);
        push_branch(MODE_PREDICT, 32'hFFFF_FFFF);
        // walk up into saturation at fifteen
        repeat (8) push_branch(MODE_LEARN_TAKEN, 32'h0000_0400);
        push_branch(MODE_PREDICT, 32'h0000_0400);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            thr_pick = $urandom_range(1, 14);
            thr      = (p == 4) ? thr_pick[CTR_W-1:0] : PHASE_THRESHOLDS[p];
            write_threshold(thr);
            if (p == 1) begin
                // keep branches flowing while the result side holds off
                hold_off_req <= 1'b1;
                burst_left   = 600;
            end
            run_phase(ITEMS_PER_PHASE);
        end

        s_valid <= 1'b0;
        wait (chk_results >= branches_sent);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d branch transfers over %0d threshold settings including 0 and 15",
                 branches_sent, N_PHASES + 1);
        $display("%0d results checked, %0d of them table hits, %0d still expected",
                 chk_results, chk_hits, chk_pending);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
